### rtl/core/pfs_pkg.sv
// ----------------------------------------------------------------------------
// pfs_pkg
// shared types and constants of the periodic frame scheduler
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int TableEntries = 16;
    localparam int MaxResults   = 16;
    localparam int SlotW        = $clog2(TableEntries);

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_DEL   = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    typedef struct packed {
        logic        valid;
        logic        sent_once;
        logic [28:0] id;
        logic [3:0]  length;
        logic [63:0] payload;
        logic [15:0] period;
        logic [31:0] deadline;
    } t_entry;

    // command record type; the scheduler and its cells do not use it
    typedef struct packed {
        logic [2:0]  op;
        logic        go;
        logic [28:0] id;
        logic [3:0]  length;
        logic [63:0] payload;
        logic [15:0] period;
        logic [31:0] now;
    } t_cmd;

endpackage

### rtl/core/periodic_frame_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_frame_scheduler
// table of periodic frames held in a ring of slot cells that rotates one full
// turn per scan or insert pass; the head slot is processed as it passes
// ----------------------------------------------------------------------------
// delete, tick and a replacing add scan the 16-slot ring in one full turn, and
// an add of a new id takes a second turn to insert it; clear and start need no turn
// a new command is taken only while idle with no frame held or waiting at the
// output, so a tick that emits waits for its last frame to be taken
// the scan stalls only when a due frame finds the hold and output stages full
// reset: synchronous active low, empties the table and stops running
module periodic_frame_scheduler
    import pfs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // opcode[2:0], period_ms[18:3], message_id[47:19], length[51:48],
    // payload[115:52], zero[119:116]
    input  logic [119:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tx_id[28:0], tx_length[32:29], tx_payload[96:33], elapsed_ms[128:97],
    // zero[135:129]
    output logic [135:0]  m_axis_tdata,
    output logic          m_axis_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;

    t_entry ring_q [TableEntries];
    t_entry head_new;
    logic   shift;
    logic   clear_hit;

    logic [1:0]       r_state;
    logic [SlotW-1:0] r_cnt;
    logic [2:0]       r_op;
    logic [28:0]      r_id;
    logic [3:0]       r_len;
    logic [63:0]      r_pay;
    logic [15:0]      r_per;
    logic [31:0]      r_now, r_start;
    logic             r_run, r_found, r_free;
    logic [SlotW-1:0] r_free_pos;
    logic             r_hold;
    logic [135:0]     r_hold_data;
    logic             r_ovalid, r_olast;
    logic [135:0]     r_odata;

    logic             n_hold, n_ovalid, n_olast;
    logic [135:0]     n_hold_data, n_odata;

    t_entry head;
    logic   due, match, scan_step, emit, out_free;
    logic [2:0] in_op;
    logic [3:0] in_len;

    genvar g;
    for (g = 0; g < TableEntries; g++) begin : g_cell
        t_entry cin;
        if (g == TableEntries - 1) begin : g_tail
            assign cin = head_new;
        end else begin : g_mid
            assign cin = ring_q[g+1];
        end
        pfs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (clear_hit),
            .i_shift (shift),
            .i_entry (cin),
            .o_entry (ring_q[g])
        );
    end

    assign head   = ring_q[0];
    assign in_op  = s_axis_tdata[2:0];
    assign in_len = (s_axis_tdata[51:48] > 4'd8) ? 4'd8 : s_axis_tdata[51:48];
    assign match  = head.valid && (head.id == r_id);
    assign due    = head.valid && (!head.sent_once || head.deadline - r_now >= 32'h8000_0000);
    assign clear_hit = s_axis_tvalid && s_axis_tready && (in_op == OP_CLEAR);

    // a frame to emit needs the hold stage free or the output able to take the held one
    assign emit      = (r_state == S_SCAN) && (r_op == OP_TICK) && r_run && due;
    assign out_free  = !r_ovalid || m_axis_tready;
    assign scan_step = (r_state == S_SCAN) && !(emit && r_hold && !out_free);
    assign shift = scan_step || (r_state == S_ADD);
    assign s_axis_tready = (r_state == S_IDLE) && !r_hold && !r_ovalid;

    always_comb begin
        head_new = head;
        if (r_state == S_ADD) begin
            if (r_cnt == r_free_pos && r_free) begin
                head_new.valid     = 1'b1;
                head_new.sent_once = 1'b0;
                head_new.id        = r_id;
                head_new.length    = r_len;
                head_new.payload   = r_pay;
                head_new.period    = r_per;
                head_new.deadline  = '0;
            end
        end else begin
            unique case (r_op)
                OP_ADD: begin
                    if (match) begin
                        head_new.sent_once = 1'b0;
                        head_new.length    = r_len;
                        head_new.payload   = r_pay;
                        head_new.period    = r_per;
                        head_new.deadline  = '0;
                    end
                end
                OP_DEL: begin
                    if (match) begin
                        head_new.valid     = 1'b0;
                        head_new.sent_once = 1'b0;
                    end
                end
                OP_TICK: begin
                    if (r_run && due) begin
                        head_new.sent_once = 1'b1;
                        head_new.deadline  = r_now + {16'd0, head.period};
                    end
                end
                default: ;
            endcase
        end
    end

    // hold stage and output register
    always_comb begin
        n_hold      = r_hold;
        n_hold_data = r_hold_data;
        n_ovalid    = r_ovalid && !m_axis_tready;
        n_odata     = r_odata;
        n_olast     = r_olast;
        if (emit && scan_step) begin
            // a new frame shows the held one is not last
            if (r_hold) begin
                n_ovalid = 1'b1;
                n_odata  = r_hold_data;
                n_olast  = 1'b0;
            end
            n_hold      = 1'b1;
            n_hold_data = {7'd0, r_now - r_start, head.payload, head.length, head.id};
        end else if (r_state != S_SCAN && r_hold && out_free) begin
            // scan over, the held frame is the last one
            n_ovalid = 1'b1;
            n_odata  = r_hold_data;
            n_olast  = 1'b1;
            n_hold   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_now     <= '0;
            r_start   <= '0;
            r_run     <= 1'b0;
            r_hold    <= 1'b0;
            r_ovalid  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_hold      <= n_hold;
            r_hold_data <= n_hold_data;
            r_ovalid    <= n_ovalid;
            r_odata     <= n_odata;
            r_olast     <= n_olast;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op    <= in_op;
                        r_id    <= s_axis_tdata[47:19];
                        r_len   <= in_len;
                        r_pay   <= s_axis_tdata[115:52];
                        r_per   <= s_axis_tdata[18:3];
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_free  <= 1'b0;
                        unique case (in_op) inside
                            OP_ADD, OP_DEL: begin
                                r_run   <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            OP_CLEAR: r_run <= 1'b0;
                            OP_START: begin
                                r_run   <= 1'b1;
                                r_start <= r_now;
                            end
                            OP_TICK: begin
                                r_now   <= r_now + 32'd1;
                                r_state <= S_SCAN;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_step) begin
                        if (r_op == OP_ADD) begin
                            if (match) r_found <= 1'b1;
                            if (!head.valid && !r_free) begin
                                r_free     <= 1'b1;
                                r_free_pos <= r_cnt;
                            end
                        end
                        if (r_cnt == SlotW'(TableEntries - 1)) begin
                            r_cnt <= '0;
                            if (r_op == OP_ADD && !r_found && !match)
                                r_state <= S_ADD;
                            else
                                r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                S_ADD: begin
                    if (r_cnt == SlotW'(TableEntries - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_hold)
        else $error("input taken while a frame is held");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output frame dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (r_op == OP_ADD))
        else $error("insert pass without add");

endmodule

### rtl/core/pfs_cell.sv
// ----------------------------------------------------------------------------
// pfs_cell
// one table slot in the rotating ring of slots
// ----------------------------------------------------------------------------
module pfs_cell
    import pfs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_clear,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid     <= 1'b0;
            r_entry.sent_once <= 1'b0;
        end else if (i_clear) begin
            r_entry.valid     <= 1'b0;
            r_entry.sent_once <= 1'b0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule
